// ===== design/pilm_pkg.sv =====
// Shared types, codes and helpers for the priority lock manager.
`default_nettype none

package pilm_pkg;

   localparam int TASK_SLOTS_DEF     = 8;
   localparam int RESOURCE_SLOTS_DEF = 8;
   localparam int PRIORITY_BITS_DEF  = 8;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CEIL   = 4'd3;

   localparam logic [1:0] MODE_INHERIT = 2'd1;
   localparam logic [1:0] MODE_CEILING = 2'd2;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_ACQUIRED = 2'd0,
      ST_BLOCKED  = 2'd1,
      ST_RELEASED = 2'd2,
      ST_ERROR    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ALU_MIN = 2'd0,
      ALU_INC = 2'd1,
      ALU_DEC = 2'd2,
      ALU_EQ  = 2'd3
   } alu_op_type;

   // write strobes from the sequencer into the tables
   typedef struct packed {
      logic owner_we;
      logic held_we;
      logic eff_we;
      logic blk_set;
      logic blk_clr;
      logic reload;
   } tbl_wr_type;

   // byte i of a packed priority word; slots past eight read as zero
   function automatic logic [7:0] packed_byte(input logic [63:0] words,
                                              input int unsigned idx);
      logic [63:0] sh;
      sh = '0;
      if (idx >= 8) begin
         return 8'd0;
      end
      sh = words >> (idx * 8);
      return sh[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/pilm_channels.sv =====
// Handshake channel interfaces: request, response and register write.
`default_nettype none

interface pilm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [2:0] task_index;
   logic [2:0] resource_index;

   modport source (output valid, cmd, task_index, resource_index, input ready);
   modport sink   (input valid, cmd, task_index, resource_index, output ready);
endinterface

interface pilm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] owner_task;
   logic [7:0] task_priority;
   logic [7:0] owner_priority;
   logic [7:0] woken_tasks;

   modport source (output valid, status, owner_task, task_priority, owner_priority,
                   woken_tasks, input ready);
   modport sink   (input valid, status, owner_task, task_priority, owner_priority,
                   woken_tasks, output ready);
endinterface

interface pilm_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/pilm_alu.sv =====
// Shared compare / count unit used by the grant, ceiling, block, release and wake-scan steps.
`default_nettype none

module pilm_alu #(
   parameter int W = 8
) (
   input  var pilm_pkg::alu_op_type op,
   input  wire logic [W-1:0]        a,
   input  wire logic [W-1:0]        b,
   output logic [W-1:0]             y,
   output logic                     flag
);

   always_comb begin
      y    = a;
      flag = 1'b0;
      case (op)
         pilm_pkg::ALU_MIN: begin
            // flag: a is less urgent than b, y is the more urgent one
            flag = a > b;
            y    = (a > b) ? b : a;
         end
         pilm_pkg::ALU_INC: begin
            y = a + W'(1);
         end
         pilm_pkg::ALU_DEC: begin
            y    = (a == '0) ? '0 : a - W'(1);
            flag = (a == '0) || (a == W'(1));
         end
         pilm_pkg::ALU_EQ: begin
            flag = a == b;
         end
         default: begin
            y    = a;
            flag = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/pilm_state.sv =====
// Lock tables: resource holders, held counts, effective priorities, wait list.
`default_nettype none

module pilm_state #(
   parameter int TASK_SLOTS     = pilm_pkg::TASK_SLOTS_DEF,
   parameter int RESOURCE_SLOTS = pilm_pkg::RESOURCE_SLOTS_DEF,
   parameter int PRIORITY_BITS  = pilm_pkg::PRIORITY_BITS_DEF,
   localparam int TI_W  = $clog2(TASK_SLOTS),
   localparam int RI_W  = $clog2(RESOURCE_SLOTS),
   localparam int OW    = $clog2(TASK_SLOTS + 1),
   localparam int CNT_W = $clog2(RESOURCE_SLOTS + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  var pilm_pkg::tbl_wr_type      wr,
   input  wire logic [TI_W-1:0]          task_sel,
   input  wire logic [RI_W-1:0]          res_sel,
   input  wire logic [TI_W-1:0]          eff_addr,
   input  wire logic [TI_W-1:0]          scan_sel,
   input  wire logic [OW-1:0]            owner_wdata,
   input  wire logic [CNT_W-1:0]         held_wdata,
   input  wire logic [PRIORITY_BITS-1:0] eff_wdata,
   input  wire logic [PRIORITY_BITS-1:0] reload_prio [TASK_SLOTS],
   output logic [OW-1:0]                 owner_rd,
   output logic [CNT_W-1:0]              held_rd,
   output logic [PRIORITY_BITS-1:0]      eff_rd,
   output logic                          blk_rd,
   output logic [RI_W-1:0]               await_rd
);

   logic [OW-1:0]            owner_ff [RESOURCE_SLOTS];
   logic [OW-1:0]            owner_in [RESOURCE_SLOTS];
   logic [CNT_W-1:0]         held_ff  [TASK_SLOTS];
   logic [CNT_W-1:0]         held_in  [TASK_SLOTS];
   logic [PRIORITY_BITS-1:0] eff_ff   [TASK_SLOTS];
   logic [PRIORITY_BITS-1:0] eff_in   [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]    blk_ff;
   logic [TASK_SLOTS-1:0]    blk_in;
   logic [RI_W-1:0]          await_ff [TASK_SLOTS];
   logic [RI_W-1:0]          await_in [TASK_SLOTS];

   always_comb begin
      owner_in = owner_ff;
      held_in  = held_ff;
      eff_in   = eff_ff;
      blk_in   = blk_ff;
      await_in = await_ff;
      if (wr.owner_we) begin
         owner_in[res_sel] = owner_wdata;
      end
      if (wr.held_we) begin
         held_in[task_sel] = held_wdata;
      end
      if (wr.reload) begin
         eff_in = reload_prio;
      end else if (wr.eff_we) begin
         eff_in[eff_addr] = eff_wdata;
      end
      if (wr.blk_set) begin
         blk_in[task_sel]   = 1'b1;
         await_in[task_sel] = res_sel;
      end
      if (wr.blk_clr) begin
         blk_in[scan_sel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RESOURCE_SLOTS; i++) begin
            owner_ff[i] <= OW'(TASK_SLOTS);
         end
         for (int i = 0; i < TASK_SLOTS; i++) begin
            held_ff[i] <= '0;
            eff_ff[i]  <= '0;
         end
         blk_ff <= '0;
      end else begin
         owner_ff <= owner_in;
         held_ff  <= held_in;
         eff_ff   <= eff_in;
         blk_ff   <= blk_in;
      end
   end

   // wait list entries are only read while their blocked bit is set
   always_ff @(posedge clock) begin
      await_ff <= await_in;
   end

   assign owner_rd = owner_ff[res_sel];
   assign held_rd  = held_ff[task_sel];
   assign eff_rd   = eff_ff[eff_addr];
   assign blk_rd   = blk_ff[scan_sel];
   assign await_rd = await_ff[scan_sel];

endmodule

`default_nettype wire

// ===== design/priority_inheritance_lock_manager.sv =====
// Path of a request: an error goes from lookup to response, a blocked acquire via the
// block step, a granted acquire via the grant step (plus the ceiling step under the
// ceiling policy), a release via the free step and a wake scan of min(active_tasks,
// TASK_SLOTS) tasks, one task checked per cycle. One request at a time: the next
// word is taken the cycle after a result is loaded; a held response stalls that load only.
// Synchronous reset frees every resource, clears counts, waits and priorities.
`default_nettype none

module priority_inheritance_lock_manager #(
   parameter int TASK_SLOTS     = pilm_pkg::TASK_SLOTS_DEF,
   parameter int RESOURCE_SLOTS = pilm_pkg::RESOURCE_SLOTS_DEF,
   parameter int PRIORITY_BITS  = pilm_pkg::PRIORITY_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pilm_req_if.sink   req_port,
   pilm_rsp_if.source rsp_port,
   pilm_csr_if.sink   csr_port
);

   localparam int TI_W  = $clog2(TASK_SLOTS);
   localparam int RI_W  = $clog2(RESOURCE_SLOTS);
   localparam int OW    = $clog2(TASK_SLOTS + 1);
   localparam int CNT_W = $clog2(RESOURCE_SLOTS + 1);
   localparam int PB    = PRIORITY_BITS;
   localparam int W1    = (PB > CNT_W) ? PB : CNT_W;
   localparam int ALU_W = (W1 > RI_W) ? W1 : RI_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LOOKUP = 8'b0000_0010,
      S_GRANT  = 8'b0000_0100,
      S_CEIL   = 8'b0000_1000,
      S_BLOCK  = 8'b0001_0000,
      S_FREE   = 8'b0010_0000,
      S_SCAN   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [2:0]           task_ff, task_in;
   logic [2:0]           res_ff, res_in;
   logic [OW-1:0]        h_ff, h_in;
   pilm_pkg::status_type status_ff, status_in;
   logic [2:0]           owner_out_ff, owner_out_in;
   logic [PB-1:0]        tprio_ff, tprio_in;
   logic [PB-1:0]        oprio_ff, oprio_in;
   logic [7:0]           woken_ff, woken_in;
   logic [TI_W-1:0]      scan_ff, scan_in;

   logic [1:0]           mode_ff, mode_in;
   logic [3:0]           active_ff, active_in;
   logic [63:0]          base_ff, base_in;
   logic [63:0]          ceil_ff, ceil_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   pilm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [2:0]           rsp_owner_ff, rsp_owner_in;
   logic [7:0]           rsp_tprio_ff, rsp_tprio_in;
   logic [7:0]           rsp_oprio_ff, rsp_oprio_in;
   logic [7:0]           rsp_woken_ff, rsp_woken_in;

   pilm_pkg::tbl_wr_type wr;
   logic [TI_W-1:0]      task_sel, res_task_unused, eff_addr;
   logic [RI_W-1:0]      res_sel;
   logic [OW-1:0]        owner_wdata;
   logic [CNT_W-1:0]     held_wdata;
   logic [PB-1:0]        eff_wdata;
   logic [PB-1:0]        reload_prio [TASK_SLOTS];
   logic [PB-1:0]        base_prio [TASK_SLOTS];
   logic [PB-1:0]        ceil_prio;
   logic [OW-1:0]        owner_rd;
   logic [CNT_W-1:0]     held_rd;
   logic [PB-1:0]        eff_rd;
   logic                 blk_rd;
   logic [RI_W-1:0]      await_rd;

   pilm_pkg::alu_op_type alu_op;
   logic [ALU_W-1:0]     alu_a, alu_b, alu_y;
   logic                 alu_flag;

   logic                 req_take, rsp_free, in_range, csr_take;
   logic [OW-1:0]        scan_lim;

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign csr_take       = csr_port.valid;
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;

   assign task_sel = TI_W'(task_ff);
   assign res_sel  = RI_W'(res_ff);
   assign in_range = (32'(task_ff) < TASK_SLOTS) && (32'(res_ff) < RESOURCE_SLOTS);
   assign scan_lim = (32'(active_ff) < TASK_SLOTS) ? OW'(active_ff) : OW'(TASK_SLOTS);
   assign eff_addr = (state_ff == S_BLOCK) ? TI_W'(h_ff) : task_sel;
   assign res_task_unused = '0;
   assign ceil_prio = PB'(pilm_pkg::packed_byte(ceil_ff, 32'(res_ff)));

   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         base_prio[i]   = PB'(pilm_pkg::packed_byte(base_ff, i));
         reload_prio[i] = PB'(pilm_pkg::packed_byte(csr_port.data, i));
      end
   end

   // register writes
   always_comb begin
      mode_in   = mode_ff;
      active_in = active_ff;
      base_in   = base_ff;
      ceil_in   = ceil_ff;
      if (csr_take) begin
         case (csr_port.index)
            pilm_pkg::CSR_MODE:   mode_in   = csr_port.data[1:0];
            pilm_pkg::CSR_ACTIVE: active_in = csr_port.data[3:0];
            pilm_pkg::CSR_BASE:   base_in   = csr_port.data;
            pilm_pkg::CSR_CEIL:   ceil_in   = csr_port.data;
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      task_in      = task_ff;
      res_in       = res_ff;
      h_in         = h_ff;
      status_in    = status_ff;
      owner_out_in = owner_out_ff;
      tprio_in     = tprio_ff;
      oprio_in     = oprio_ff;
      woken_in     = woken_ff;
      scan_in      = scan_ff;

      wr          = '0;
      wr.reload   = csr_take && (csr_port.index == pilm_pkg::CSR_BASE);
      owner_wdata = OW'(task_ff);
      held_wdata  = held_rd;
      eff_wdata   = PB'(alu_y);

      alu_op = pilm_pkg::ALU_EQ;
      alu_a  = ALU_W'(await_rd);
      alu_b  = ALU_W'(res_sel);

      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_tprio_in  = rsp_tprio_ff;
      rsp_oprio_in  = rsp_oprio_ff;
      rsp_woken_in  = rsp_woken_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in       = req_port.cmd;
               task_in      = req_port.task_index;
               res_in       = req_port.resource_index;
               status_in    = pilm_pkg::ST_ERROR;
               owner_out_in = '0;
               tprio_in     = '0;
               oprio_in     = '0;
               woken_in     = '0;
               state_in     = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (!in_range) begin
               state_in = S_DONE;
            end else begin
               tprio_in = eff_rd;
               h_in     = owner_rd;
               if (cmd_ff == pilm_pkg::CMD_ACQUIRE) begin
                  state_in = (32'(owner_rd) >= TASK_SLOTS) ? S_GRANT : S_BLOCK;
               end else if (32'(owner_rd) == 32'(task_ff)) begin
                  state_in = S_FREE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_GRANT: begin
            wr.owner_we = 1'b1;
            wr.held_we  = 1'b1;
            alu_op      = pilm_pkg::ALU_INC;
            alu_a       = ALU_W'(held_rd);
            held_wdata  = CNT_W'(alu_y);
            status_in   = pilm_pkg::ST_ACQUIRED;
            state_in    = (mode_ff == pilm_pkg::MODE_CEILING) ? S_CEIL : S_DONE;
         end
         S_CEIL: begin
            alu_op = pilm_pkg::ALU_MIN;
            alu_a  = ALU_W'(tprio_ff);
            alu_b  = ALU_W'(ceil_prio);
            if (alu_flag) begin
               wr.eff_we = 1'b1;
               tprio_in  = PB'(alu_y);
            end
            state_in = S_DONE;
         end
         S_BLOCK: begin
            // eff_addr points at the holder here
            wr.blk_set   = 1'b1;
            alu_op       = pilm_pkg::ALU_MIN;
            alu_a        = ALU_W'(eff_rd);
            alu_b        = ALU_W'(tprio_ff);
            status_in    = pilm_pkg::ST_BLOCKED;
            owner_out_in = 3'(h_ff);
            if (mode_ff == pilm_pkg::MODE_INHERIT) begin
               oprio_in  = PB'(alu_y);
               wr.eff_we = alu_flag;
            end else begin
               oprio_in = eff_rd;
            end
            state_in = S_DONE;
         end
         S_FREE: begin
            wr.owner_we = 1'b1;
            owner_wdata = OW'(TASK_SLOTS);
            wr.held_we  = 1'b1;
            alu_op      = pilm_pkg::ALU_DEC;
            alu_a       = ALU_W'(held_rd);
            held_wdata  = CNT_W'(alu_y);
            if (alu_flag) begin
               // last resource gone: back to base priority
               wr.eff_we = 1'b1;
               eff_wdata = base_prio[task_sel];
               tprio_in  = base_prio[task_sel];
            end
            status_in = pilm_pkg::ST_RELEASED;
            scan_in   = '0;
            state_in  = (scan_lim != '0) ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            if (blk_rd && alu_flag) begin
               wr.blk_clr = 1'b1;
               woken_in   = woken_ff | 8'(32'd1 << scan_ff);
            end
            if (32'(scan_ff) + 1 >= 32'(scan_lim)) begin
               state_in = S_DONE;
            end else begin
               scan_in = TI_W'(32'(scan_ff) + 1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_owner_in  = owner_out_ff;
               rsp_tprio_in  = 8'(tprio_ff);
               rsp_oprio_in  = 8'(oprio_ff);
               rsp_woken_in  = woken_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         active_ff    <= 4'd8;
         base_ff      <= '0;
         ceil_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         active_ff    <= active_in;
         base_ff      <= base_in;
         ceil_ff      <= ceil_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      task_ff       <= task_in;
      res_ff        <= res_in;
      h_ff          <= h_in;
      status_ff     <= status_in;
      owner_out_ff  <= owner_out_in;
      tprio_ff      <= tprio_in;
      oprio_ff      <= oprio_in;
      woken_ff      <= woken_in;
      scan_ff       <= scan_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_tprio_ff  <= rsp_tprio_in;
      rsp_oprio_ff  <= rsp_oprio_in;
      rsp_woken_ff  <= rsp_woken_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.status         = rsp_status_ff;
   assign rsp_port.owner_task     = rsp_owner_ff;
   assign rsp_port.task_priority  = rsp_tprio_ff;
   assign rsp_port.owner_priority = rsp_oprio_ff;
   assign rsp_port.woken_tasks    = rsp_woken_ff;

   pilm_state #(
      .TASK_SLOTS     (TASK_SLOTS),
      .RESOURCE_SLOTS (RESOURCE_SLOTS),
      .PRIORITY_BITS  (PRIORITY_BITS)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .task_sel    (task_sel),
      .res_sel     (res_sel),
      .eff_addr    (eff_addr),
      .scan_sel    (scan_ff | res_task_unused),
      .owner_wdata (owner_wdata),
      .held_wdata  (held_wdata),
      .eff_wdata   (eff_wdata),
      .reload_prio (reload_prio),
      .owner_rd    (owner_rd),
      .held_rd     (held_rd),
      .eff_rd      (eff_rd),
      .blk_rd      (blk_rd),
      .await_rd    (await_rd)
   );

   pilm_alu #(
      .W (ALU_W)
   ) u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .y    (alu_y),
      .flag (alu_flag)
   );

   a_take_lookup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_LOOKUP)
      else $error("accepted word did not start a lookup");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> 32'(scan_ff) < 32'(scan_lim))
      else $error("wake scan ran past the active task count");

   a_holder_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BLOCK |-> 32'(h_ff) < TASK_SLOTS)
      else $error("blocked on a free resource");

   a_holder_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FREE |-> held_rd != '0)
      else $error("release by a task holding nothing");

   a_woken_release: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && (rsp_port.status != pilm_pkg::ST_RELEASED)
         |-> rsp_port.woken_tasks == 8'd0)
      else $error("wake mask on a non-release response");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the priority inheritance / ceiling lock manager.
`default_nettype none

localparam logic [1:0] MODE_NONE  = 2'd0;
localparam logic [1:0] MODE_SPARE = 2'd3;
localparam logic [3:0] FREE_SLOT  = 4'd8;
localparam int         CYCLE_LIMIT = 500000;

typedef struct packed {
   pilm_pkg::status_type status;
   logic [2:0] owner_task;
   logic [7:0] task_priority;
   logic [7:0] owner_priority;
   logic [7:0] woken_tasks;
} lock_reply_type;

// Mutex table predictor plus the queue of replies it still owes.
class lock_table;
   logic [1:0]     mode;
   logic [3:0]     active;
   logic [63:0]    base_words;
   logic [63:0]    ceil_words;
   logic [3:0]     holder[8];
   logic [3:0]     held[8];
   logic [7:0]     eff[8];
   bit             blocked[8];
   logic [2:0]     awaited[8];
   lock_reply_type want_q[$];

   function new();
      mode       = MODE_NONE;
      active     = 4'd8;
      base_words = '0;
      ceil_words = '0;
      for (int i = 0; i < 8; i++) begin
         holder[i]  = FREE_SLOT;
         held[i]    = '0;
         eff[i]     = '0;
         blocked[i] = 1'b0;
         awaited[i] = '0;
      end
   endfunction

   function logic [7:0] prio_byte(input logic [63:0] words, input int idx);
      return words[8*idx +: 8];
   endfunction

   function int pending();
      return want_q.size();
   endfunction

   function logic [3:0] holder_of(input logic [2:0] r);
      return holder[r];
   endfunction

   function void write_register(input logic [3:0] idx, input logic [63:0] value);
      case (idx)
         pilm_pkg::CSR_MODE: mode = value[1:0];
         pilm_pkg::CSR_ACTIVE: active = value[3:0];
         pilm_pkg::CSR_BASE: begin
            base_words = value;
            for (int i = 0; i < 8; i++) eff[i] = prio_byte(base_words, i);
         end
         pilm_pkg::CSR_CEIL: ceil_words = value;
         default: ;
      endcase
   endfunction

   function void note_request(input logic cmd, input logic [2:0] t, input logic [2:0] r);
      lock_reply_type rep;
      logic [3:0]     h;
      logic [7:0]     ceil_prio;
      int             scan;
      rep        = '0;
      rep.status = pilm_pkg::ST_ERROR;
      h          = holder[r];
      if (cmd == pilm_pkg::CMD_ACQUIRE) begin
         if (h == FREE_SLOT) begin
            holder[r] = {1'b0, t};
            held[t]   = held[t] + 4'd1;
            ceil_prio = prio_byte(ceil_words, r);
            if (mode == pilm_pkg::MODE_CEILING && eff[t] > ceil_prio) eff[t] = ceil_prio;
            rep.status = pilm_pkg::ST_ACQUIRED;
         end else begin
            blocked[t] = 1'b1;
            awaited[t] = r;
            if (mode == pilm_pkg::MODE_INHERIT && eff[h] > eff[t]) eff[h] = eff[t];
            rep.status         = pilm_pkg::ST_BLOCKED;
            rep.owner_task     = h[2:0];
            rep.owner_priority = eff[h];
         end
      end else if (h == {1'b0, t}) begin
         holder[r] = FREE_SLOT;
         if (held[t] != 0) held[t] = held[t] - 4'd1;
         if (held[t] == 0) eff[t] = prio_byte(base_words, t);
         // only the first active_tasks tasks get scanned for wake-up
         scan = (active < 8) ? active : 8;
         for (int i = 0; i < scan; i++) begin
            if (blocked[i] && awaited[i] == r) begin
               blocked[i]          = 1'b0;
               rep.woken_tasks[i]  = 1'b1;
            end
         end
         rep.status = pilm_pkg::ST_RELEASED;
      end
      rep.task_priority = eff[t];
      want_q.push_back(rep);
   endfunction

   function string check_response(input lock_reply_type got);
      lock_reply_type want;
      string          msg;
      if (want_q.size() == 0)
         return $sformatf("unexpected response word, status %0d", got.status);
      want = want_q.pop_front();
      msg  = "";
      if (got.status !== want.status)
         msg = {msg, $sformatf(" status %0d/%0d", got.status, want.status)};
      if (got.owner_task !== want.owner_task)
         msg = {msg, $sformatf(" owner_task %0d/%0d", got.owner_task, want.owner_task)};
      if (got.task_priority !== want.task_priority)
         msg = {msg, $sformatf(" task_priority %0h/%0h", got.task_priority,
                               want.task_priority)};
      if (got.owner_priority !== want.owner_priority)
         msg = {msg, $sformatf(" owner_priority %0h/%0h", got.owner_priority,
                               want.owner_priority)};
      if (got.woken_tasks !== want.woken_tasks)
         msg = {msg, $sformatf(" woken_tasks %0h/%0h", got.woken_tasks, want.woken_tasks)};
      if (msg == "") return "";
      return {"response word (got/want):", msg};
   endfunction
endclass

module tb;

   logic clock;
   logic reset;
   int   mismatches = 0;
   int   cycles = 0;
   int   idle_mode = 0;
   int   random_sent = 0;

   pilm_req_if req_if();
   pilm_rsp_if rsp_if();
   pilm_csr_if csr_if();

   lock_table locks = new();

   priority_inheritance_lock_manager u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("ERROR at cycle %0d: %s", cycles, what);
   endtask

   // idle_mode 0: sender idles 10%, receiver 84%; 1: swapped; 2: no idling
   function automatic int sender_gap_pct();
      case (idle_mode)
         0: return 10;
         1: return 84;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode)
         0: return 84;
         1: return 10;
         default: return 0;
      endcase
   endfunction

   task automatic send_request(input logic cmd, input logic [2:0] t, input logic [2:0] r);
      while ($urandom_range(99) < sender_gap_pct()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.cmd            <= cmd;
      req_if.task_index     <= t;
      req_if.resource_index <= r;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      locks.note_request(cmd, t, r);
   endtask

   // hold off the sender until every owed response word is back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (locks.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] idx, input logic [63:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      locks.write_register(idx, value);
   endtask

   task automatic apply_settings(input logic [1:0] mode, input logic [3:0] active,
                                 input logic [63:0] base, input logic [63:0] ceil);
      drain_results();
      write_csr(pilm_pkg::CSR_MODE, {62'd0, mode});
      write_csr(pilm_pkg::CSR_ACTIVE, {60'd0, active});
      write_csr(pilm_pkg::CSR_BASE, base);
      write_csr(pilm_pkg::CSR_CEIL, ceil);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [1:0] mode, input logic [3:0] active,
                            input logic [63:0] base, input logic [63:0] ceil,
                            input int count);
      int         roll;
      logic [2:0] t;
      logic [2:0] r;
      logic [3:0] h;
      apply_settings(mode, active, base, ceil);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         t    = 3'($urandom_range(7));
         r    = 3'($urandom_range(7));
         h    = locks.holder_of(r);
         if (roll < 40) begin
            send_request(pilm_pkg::CMD_ACQUIRE, t, r);
         end else if (roll < 85) begin
            // mostly proper releases by the holder, else grab the free resource
            if (h != FREE_SLOT) send_request(pilm_pkg::CMD_RELEASE, h[2:0], r);
            else send_request(pilm_pkg::CMD_ACQUIRE, t, r);
         end else begin
            send_request(pilm_pkg::CMD_RELEASE, t, r);
         end
         random_sent++;
         idle_mode <= (random_sent < 460) ? 0 : (random_sent < 920) ? 1 : 2;
      end
   endtask

   always @(posedge clock) begin
      lock_reply_type got;
      string          msg;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.status         = pilm_pkg::status_type'(rsp_if.status);
            got.owner_task     = rsp_if.owner_task;
            got.task_priority  = rsp_if.task_priority;
            got.owner_priority = rsp_if.owner_priority;
            got.woken_tasks    = rsp_if.woken_tasks;
            msg = locks.check_response(got);
            if (msg != "") report_mismatch(msg);
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.cmd            <= pilm_pkg::CMD_ACQUIRE;
      req_if.task_index     <= '0;
      req_if.resource_index <= '0;
      csr_if.valid          <= 1'b0;
      csr_if.index          <= pilm_pkg::CSR_MODE;
      csr_if.data           <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // inheritance: task 7 is the most urgent, task 0 the least
      apply_settings(pilm_pkg::MODE_INHERIT, 4'd8, 64'h0560_5040_3020_10F0,
                     64'h0011_2233_4455_66FF);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd0, 3'd0);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd0, 3'd0);   // blocked on its own resource
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd7, 3'd0);   // holder inherits urgent priority
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd3, 3'd7);
      send_request(pilm_pkg::CMD_RELEASE, 3'd5, 3'd7);   // not the holder
      send_request(pilm_pkg::CMD_RELEASE, 3'd3, 3'd7);
      send_request(pilm_pkg::CMD_RELEASE, 3'd0, 3'd0);   // back to base, wakes 0 and 7
      send_request(pilm_pkg::CMD_RELEASE, 3'd0, 3'd0);   // already free

      // ceiling, active count above the slot count
      apply_settings(pilm_pkg::MODE_CEILING, 4'd15, 64'h0560_5040_3020_10F0,
                     64'h0011_2233_4455_66FF);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd0, 3'd7);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd0, 3'd0);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd7, 3'd7);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd6, 3'd0);
      send_request(pilm_pkg::CMD_RELEASE, 3'd0, 3'd7);   // still holds one: keeps ceiling
      send_request(pilm_pkg::CMD_RELEASE, 3'd0, 3'd0);

      // unused mode, nobody scanned
      apply_settings(MODE_SPARE, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd7, 3'd3);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd1, 3'd3);
      send_request(pilm_pkg::CMD_RELEASE, 3'd7, 3'd3);

      // no protocol, only task 0 scanned
      apply_settings(MODE_NONE, 4'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd2, 3'd5);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd0, 3'd5);
      send_request(pilm_pkg::CMD_ACQUIRE, 3'd4, 3'd5);
      send_request(pilm_pkg::CMD_RELEASE, 3'd2, 3'd5);

      run_phase(pilm_pkg::MODE_INHERIT, 4'd8, {$urandom(), $urandom()},
                {$urandom(), $urandom()}, 197);
      run_phase(pilm_pkg::MODE_CEILING, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF,
                {$urandom(), $urandom()}, 197);
      run_phase(MODE_NONE, 4'd1, {$urandom(), $urandom()}, 64'd0, 197);
      run_phase(MODE_SPARE, 4'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 197);
      run_phase(pilm_pkg::MODE_CEILING, 4'd15, {$urandom(), $urandom()}, 64'd0, 197);
      run_phase(pilm_pkg::MODE_INHERIT, 4'd3, {$urandom(), $urandom()},
                {$urandom(), $urandom()}, 197);
      run_phase(pilm_pkg::MODE_CEILING, 4'd8, {$urandom(), $urandom()},
                {$urandom(), $urandom()}, 197);

      drain_results();
      // room for any stray word after the last release scan
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
